[sv/multi_channel_watchdog_assert.svh]
// Assertion macros shared by the watchdog checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef MULTI_CHANNEL_WATCHDOG_ASSERT_SVH
`define MULTI_CHANNEL_WATCHDOG_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCW_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog assertion failed");

// Next-cycle implication, disabled during reset.
`define MCW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog assertion failed");

`endif

[sv/mcw_pkg.sv]
// Shared types and constants for the multi-channel watchdog.
// Used by mcw_cell, multi_channel_watchdog and mcw_checker.
package mcw_pkg;

  localparam int LIFELINES = 8;

  // Field widths of the request and result channels.
  localparam int SLOT_W     = 3;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 3;
  localparam int OUT_MASK_W = 8;

  // Cell index width: wide enough for every cell and for a request slot.
  localparam int CNT_W    = (LIFELINES > 1) ? $clog2(LIFELINES) : 1;
  localparam int SLOT_X_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_FEED     = 2'd1,
    OP_CHECK    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FEED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BREACH   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MASK     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

  // Request token that walks the cell chain.
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic [TIME_W-1:0]     now_ms;
    logic [TIME_W-1:0]     deadline;
    logic [SLOT_W-1:0]     slot;
    logic                  hit;
    logic [SLOT_W-1:0]     idx;
    logic [OUT_MASK_W-1:0] mask;
  } token_t;

  // Breach event raised by one cell.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } evt_t;

endpackage

[sv/mcw_cell.sv]
// One lifeline cell: holds a slot's flags, feed time and deadline.
// Depends on mcw_pkg; instantiated in a chain by multi_channel_watchdog.
module mcw_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [mcw_pkg::SLOT_X_W-1:0]  cell_idx,
  input  mcw_pkg::token_t               tok_in,
  output mcw_pkg::token_t               tok_out,
  output mcw_pkg::evt_t                 evt
);

  logic                         armed;
  logic                         breached;
  logic [mcw_pkg::TIME_W-1:0]   last_feed;
  logic [mcw_pkg::TIME_W-1:0]   deadline_q;

  mcw_pkg::token_t              tok_next;
  logic [mcw_pkg::TIME_W-1:0]   age;
  logic                         overdue;
  logic                         claim;
  logic                         feed_hit;
  logic                         fire;
  logic                         step;

  assign step     = adv && tok_in.valid;
  assign age      = tok_in.now_ms - last_feed;
  assign overdue  = armed && (age > deadline_q);
  assign claim    = (tok_in.op == mcw_pkg::OP_REGISTER) && !armed && !tok_in.hit;
  assign feed_hit = (tok_in.op == mcw_pkg::OP_FEED) && armed &&
                    (mcw_pkg::SLOT_X_W'(tok_in.slot) == cell_idx);
  assign fire     = (tok_in.op == mcw_pkg::OP_CHECK) && overdue && !breached;

  always_comb begin
    tok_next = tok_in;
    evt      = '0;
    case (tok_in.op)
      mcw_pkg::OP_REGISTER: begin
        if (claim) begin
          tok_next.hit = 1'b1;
          tok_next.idx = cell_idx[mcw_pkg::SLOT_W-1:0];
        end
      end
      mcw_pkg::OP_FEED: begin
        if (feed_hit) tok_next.hit = 1'b1;
      end
      mcw_pkg::OP_CHECK: begin
        // Slots past the mask width cannot be shown.
        if (overdue && (int'(cell_idx) < mcw_pkg::OUT_MASK_W)) begin
          tok_next.mask = tok_in.mask |
                          (mcw_pkg::OUT_MASK_W'(1) << cell_idx[mcw_pkg::SLOT_W-1:0]);
        end
        evt.valid = fire && tok_in.valid;
        evt.idx   = cell_idx[mcw_pkg::SLOT_W-1:0];
      end
      mcw_pkg::OP_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b0;
      breached <= 1'b0;
    end else if (step) begin
      case (tok_in.op)
        mcw_pkg::OP_REGISTER: begin
          if (claim) begin
            armed    <= 1'b1;
            breached <= 1'b0;
          end
        end
        mcw_pkg::OP_FEED: begin
          if (feed_hit) breached <= 1'b0;
        end
        mcw_pkg::OP_CHECK: begin
          if (fire) breached <= 1'b1;
        end
        mcw_pkg::OP_CLEAR: begin
          armed    <= 1'b0;
          breached <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step && claim) begin
      last_feed  <= tok_in.now_ms;
      deadline_q <= tok_in.deadline;
    end else if (step && feed_hit) begin
      last_feed  <= tok_in.now_ms;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

[sv/multi_channel_watchdog.sv]
// Channel   | Handshake              | Payload
// request   | in_valid / in_ready    | opcode, now_ms, deadline, slot
// result    | out_valid / out_ready  | kind, ok, slot_index, overdue_mask, last
//
// A request walks a chain of LIFELINES cells, one cell per cycle while the result
// side does not stall; the next request is accepted only after the final result
// of the last one is registered. Each breach event and the final result use the
// single output register; while it is held, the whole chain holds too.
// Reset is synchronous and disarms every slot. Depends on mcw_pkg and mcw_cell.
module multi_channel_watchdog (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic [mcw_pkg::TIME_W-1:0]        now_ms,
  input  logic [mcw_pkg::TIME_W-1:0]        deadline,
  input  logic [mcw_pkg::SLOT_W-1:0]        slot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mcw_pkg::KIND_W-1:0]        kind,
  output logic                              ok,
  output logic [mcw_pkg::SLOT_W-1:0]        slot_index,
  output logic [mcw_pkg::OUT_MASK_W-1:0]    overdue_mask,
  output logic                              last
);

  mcw_pkg::token_t tok  [mcw_pkg::LIFELINES+1];
  mcw_pkg::evt_t   evts [mcw_pkg::LIFELINES];
  mcw_pkg::evt_t   ev;
  mcw_pkg::token_t head;
  mcw_pkg::token_t tail;
  logic            busy;
  logic            adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !busy;
  assign tok[0]   = head;
  assign tail     = tok[mcw_pkg::LIFELINES];

  for (genvar i = 0; i < mcw_pkg::LIFELINES; i++) begin : g_cell
    mcw_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .cell_idx (mcw_pkg::SLOT_X_W'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .evt      (evts[i])
    );
  end

  // Only one cell holds the token, so at most one event is live.
  always_comb begin
    ev = '0;
    for (int i = 0; i < mcw_pkg::LIFELINES; i++) begin
      if (evts[i].valid) ev = evts[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      head.valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        head.valid    <= 1'b1;
        head.op       <= mcw_pkg::op_t'(opcode);
        head.now_ms   <= now_ms;
        head.deadline <= deadline;
        head.slot     <= slot;
        head.hit      <= 1'b0;
        head.idx      <= '0;
        head.mask     <= '0;
        busy          <= 1'b1;
      end else if (adv) begin
        head.valid <= 1'b0;
      end

      if (adv) begin
        if (ev.valid) begin
          out_valid    <= 1'b1;
          kind         <= mcw_pkg::KIND_BREACH;
          ok           <= 1'b0;
          slot_index   <= ev.idx;
          overdue_mask <= '0;
          last         <= 1'b0;
        end else if (tail.valid) begin
          // Request leaves the chain: emit its final result.
          out_valid    <= 1'b1;
          busy         <= 1'b0;
          last         <= 1'b1;
          ok           <= 1'b0;
          slot_index   <= '0;
          overdue_mask <= '0;
          case (tail.op)
            mcw_pkg::OP_REGISTER: begin
              kind       <= mcw_pkg::KIND_REGISTER;
              ok         <= tail.hit;
              slot_index <= tail.idx;
            end
            mcw_pkg::OP_FEED: begin
              kind <= mcw_pkg::KIND_FEED;
              ok   <= tail.hit;
            end
            mcw_pkg::OP_CHECK: begin
              kind         <= mcw_pkg::KIND_MASK;
              overdue_mask <= tail.mask;
            end
            mcw_pkg::OP_CLEAR: begin
              kind <= mcw_pkg::KIND_CLEAR;
            end
            default: begin
              kind <= mcw_pkg::KIND_CLEAR;
            end
          endcase
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

[sv/mcw_checker.sv]
// Port-level checks for the multi-channel watchdog, bound to the top level.
// Depends on mcw_pkg and multi_channel_watchdog_assert.svh.
`include "multi_channel_watchdog_assert.svh"

module mcw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mcw_pkg::KIND_W-1:0]        kind,
  input logic                              ok,
  input logic [mcw_pkg::SLOT_W-1:0]        slot_index,
  input logic [mcw_pkg::OUT_MASK_W-1:0]    overdue_mask,
  input logic                              last
);

  // A stalled result holds.
  `MCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, $stable({kind, ok, slot_index, overdue_mask, last}))

  // One request at a time: no new request right after one is taken.
  `MCW_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)

  // Only breach events come before the final result.
  `MCW_ASSERT_IMPL(a_mid_is_breach, out_valid && !last, kind == mcw_pkg::KIND_BREACH)

  // While breach events are pending, the request is still in progress.
  `MCW_ASSERT_IMPL(a_mid_busy, out_valid && !last, !in_ready)

  // The overdue mask shows only on the check mask result.
  `MCW_ASSERT_IMPL(a_mask_kind, out_valid && kind != mcw_pkg::KIND_MASK, overdue_mask == '0)

endmodule

bind multi_channel_watchdog mcw_checker u_mcw_checker (.*);

[tb/sv/tb_multi_channel_watchdog.sv]
// Self-checking testbench for multi_channel_watchdog: directed and random requests,
// predicted replies queued in order and compared field by field as they arrive.
// Depends on mcw_pkg for the opcode and reply-kind constants.
`timescale 1ns / 1ps

module tb_multi_channel_watchdog;

  localparam int TIMEOUT_NS = 3_000_000;

  typedef struct packed {
    logic [mcw_pkg::KIND_W-1:0]     kind;
    logic                           ok;
    logic [mcw_pkg::SLOT_W-1:0]     slot_index;
    logic [mcw_pkg::OUT_MASK_W-1:0] overdue_mask;
    logic                           last;
  } watchdog_reply_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     opcode;
  logic [mcw_pkg::TIME_W-1:0]     now_ms;
  logic [mcw_pkg::TIME_W-1:0]     deadline;
  logic [mcw_pkg::SLOT_W-1:0]     slot;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mcw_pkg::KIND_W-1:0]     kind;
  logic                           ok;
  logic [mcw_pkg::SLOT_W-1:0]     slot_index;
  logic [mcw_pkg::OUT_MASK_W-1:0] overdue_mask;
  logic                           last;

  // Shadow copy of the lifeline table
  logic                       armed_q    [mcw_pkg::LIFELINES];
  logic                       breached_q [mcw_pkg::LIFELINES];
  logic [mcw_pkg::TIME_W-1:0] fed_at_q   [mcw_pkg::LIFELINES];
  logic [mcw_pkg::TIME_W-1:0] allowance_q[mcw_pkg::LIFELINES];

  watchdog_reply_t            expected_replies[$];
  int                         error_count   = 0;
  int                         send_idle_pct = 0;
  int                         recv_idle_pct = 0;
  logic [mcw_pkg::TIME_W-1:0] wall_ms;

  multi_channel_watchdog dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .now_ms       (now_ms),
    .deadline     (deadline),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .ok           (ok),
    .slot_index   (slot_index),
    .overdue_mask (overdue_mask),
    .last         (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void queue_reply(logic [mcw_pkg::KIND_W-1:0] k, logic hit,
                                      logic [mcw_pkg::SLOT_W-1:0] idx,
                                      logic [mcw_pkg::OUT_MASK_W-1:0] mask, logic fin);
    watchdog_reply_t r;
    r.kind         = k;
    r.ok           = hit;
    r.slot_index   = idx;
    r.overdue_mask = mask;
    r.last         = fin;
    expected_replies.push_back(r);
  endfunction

  function automatic void predict_watchdog_reply(mcw_pkg::op_t op,
                                                 logic [mcw_pkg::TIME_W-1:0] at_ms,
                                                 logic [mcw_pkg::TIME_W-1:0] allow_ms,
                                                 logic [mcw_pkg::SLOT_W-1:0] lane);
    logic                           found;
    logic [mcw_pkg::OUT_MASK_W-1:0] late;
    case (op)
      mcw_pkg::OP_REGISTER: begin
        found = 1'b0;
        for (int i = 0; i < mcw_pkg::LIFELINES; i++) begin
          if (!found && !armed_q[i]) begin
            armed_q[i]     = 1'b1;
            breached_q[i]  = 1'b0;
            fed_at_q[i]    = at_ms;
            allowance_q[i] = allow_ms;
            queue_reply(mcw_pkg::KIND_REGISTER, 1'b1, mcw_pkg::SLOT_W'(i), '0, 1'b1);
            found = 1'b1;
          end
        end
        if (!found) queue_reply(mcw_pkg::KIND_REGISTER, 1'b0, '0, '0, 1'b1);
      end
      mcw_pkg::OP_FEED: begin
        if (int'(lane) < mcw_pkg::LIFELINES && armed_q[lane]) begin
          fed_at_q[lane]   = at_ms;
          breached_q[lane] = 1'b0;
          queue_reply(mcw_pkg::KIND_FEED, 1'b1, '0, '0, 1'b1);
        end else begin
          queue_reply(mcw_pkg::KIND_FEED, 1'b0, '0, '0, 1'b1);
        end
      end
      mcw_pkg::OP_CHECK: begin
        late = '0;
        for (int i = 0; i < mcw_pkg::LIFELINES; i++) begin
          // age wraps at 32 bits
          if (armed_q[i] &&
              (mcw_pkg::TIME_W'(at_ms - fed_at_q[i]) > allowance_q[i])) begin
            if (i < mcw_pkg::OUT_MASK_W) late[i] = 1'b1;
            if (!breached_q[i]) begin
              breached_q[i] = 1'b1;
              queue_reply(mcw_pkg::KIND_BREACH, 1'b0, mcw_pkg::SLOT_W'(i), '0, 1'b0);
            end
          end
        end
        queue_reply(mcw_pkg::KIND_MASK, 1'b0, '0, late, 1'b1);
      end
      default: begin
        for (int i = 0; i < mcw_pkg::LIFELINES; i++) begin
          armed_q[i]     = 1'b0;
          breached_q[i]  = 1'b0;
          fed_at_q[i]    = '0;
          allowance_q[i] = '0;
        end
        queue_reply(mcw_pkg::KIND_CLEAR, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_replies
    watchdog_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: kind %0d ok %0d slot_index %0d overdue_mask %h last %0d",
               kind, ok, slot_index, overdue_mask, last);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          error_count++;
        end
        if (ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok);
          error_count++;
        end
        if (slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
          error_count++;
        end
        if (overdue_mask !== want.overdue_mask) begin
          $error("overdue_mask: expected %h, got %h", want.overdue_mask, overdue_mask);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          error_count++;
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the request is accepted.
  task automatic send_request(mcw_pkg::op_t op, logic [mcw_pkg::TIME_W-1:0] at_ms,
                              logic [mcw_pkg::TIME_W-1:0] allow_ms,
                              logic [mcw_pkg::SLOT_W-1:0] lane);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    now_ms   <= at_ms;
    deadline <= allow_ms;
    slot     <= lane;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_watchdog_reply(op, at_ms, allow_ms, lane);
  endtask

  // Hold the request side until every predicted reply is back.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_fill_table();
    send_request(mcw_pkg::OP_REGISTER, 32'd0, 32'd0, 3'd7);
    send_request(mcw_pkg::OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
    for (int k = 2; k < mcw_pkg::LIFELINES; k++) begin
      send_request(mcw_pkg::OP_REGISTER, 32'd100, mcw_pkg::TIME_W'(10 * k),
                   mcw_pkg::SLOT_W'($urandom()));
    end
    // table is full now
    send_request(mcw_pkg::OP_REGISTER, 32'd150, 32'd5, 3'd0);
    wait_for_replies();
  endtask

  task automatic test_breach_once();
    send_request(mcw_pkg::OP_CHECK, 32'd200, $urandom(), 3'd0);
    send_request(mcw_pkg::OP_CHECK, 32'd200, $urandom(), 3'd7);
    send_request(mcw_pkg::OP_FEED, 32'd250, $urandom(), 3'd0);
    send_request(mcw_pkg::OP_FEED, 32'd250, $urandom(), 3'd7);
    // slot 0 breaches again after its feed, slot 7 stays in time
    send_request(mcw_pkg::OP_CHECK, 32'd251, $urandom(), 3'd0);
    send_request(mcw_pkg::OP_CHECK, 32'h8000_0000, $urandom(), 3'd0);
    wait_for_replies();
  endtask

  task automatic test_unarmed_and_wrap();
    send_request(mcw_pkg::OP_CLEAR, $urandom(), $urandom(), 3'd5);
    send_request(mcw_pkg::OP_FEED, 32'd10, 32'd0, 3'd3);
    send_request(mcw_pkg::OP_REGISTER, 32'hFFFF_FFF0, 32'h20, 3'd0);
    // age across the wrap equals the deadline first, then exceeds it
    send_request(mcw_pkg::OP_CHECK, 32'h0000_0010, 32'd0, 3'd0);
    send_request(mcw_pkg::OP_CHECK, 32'h0000_0011, 32'd0, 3'd0);
    send_request(mcw_pkg::OP_FEED, 32'h0000_0020, 32'd0, 3'd7);
    wait_for_replies();
  endtask

  task automatic test_random_traffic(int count);
    int                         pick;
    logic [mcw_pkg::TIME_W-1:0] allow_ms;
    logic [mcw_pkg::SLOT_W-1:0] lane;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) wall_ms = $urandom();
      else wall_ms = wall_ms + $urandom_range(0, 60);
      allow_ms = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 120);
      lane     = mcw_pkg::SLOT_W'($urandom());
      if (pick < 25) send_request(mcw_pkg::OP_REGISTER, wall_ms, allow_ms, lane);
      else if (pick < 60) send_request(mcw_pkg::OP_FEED, wall_ms, $urandom(), lane);
      else if (pick < 93) send_request(mcw_pkg::OP_CHECK, wall_ms, $urandom(), lane);
      else send_request(mcw_pkg::OP_CLEAR, wall_ms, $urandom(), lane);
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    opcode   = mcw_pkg::OP_REGISTER;
    now_ms   = '0;
    deadline = '0;
    slot     = '0;
    for (int i = 0; i < mcw_pkg::LIFELINES; i++) begin
      armed_q[i]     = 1'b0;
      breached_q[i]  = 1'b0;
      fed_at_q[i]    = '0;
      allowance_q[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    recv_idle_pct = 87;
    test_fill_table();
    test_breach_once();
    test_unarmed_and_wrap();

    wall_ms = $urandom();
    test_random_traffic(30);
    send_idle_pct = 87;
    recv_idle_pct = 13;
    test_random_traffic(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(30);

    wait_for_replies();
    repeat (4 * mcw_pkg::LIFELINES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
